[src/msd_pkg.sv]
// msd_pkg: widths, step counts, controller states and the command and
// status records shared by the mean / standard deviation block.
// No dependencies.
package msd_pkg;

   // defaults for the top-level parameters
   localparam int MSD_MAX_SAMPLES_DEF = 65536;
   localparam int MSD_SAMPLE_BITS_DEF = 24;

   // fixed field and datapath widths
   localparam int SAMPLE_W = 24;
   localparam int MEAN_W   = 24;
   localparam int SD_W     = 24;
   localparam int CNT_W    = 17;
   localparam int SUM_W    = 40;
   localparam int SQ_W     = 63;
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int VAR_W    = 80;
   localparam int ROOT_W   = VAR_W / 2;
   localparam int REM_W    = ROOT_W + 2;
   localparam int STEP_W   = 6;

   // iterations of each bit-serial phase
   localparam int MUL_N_STEPS = CNT_W;
   localparam int MUL_S_STEPS = SUM_W;
   localparam int SQRT_STEPS  = VAR_W / 2;
   localparam int DIV_STEPS   = SUM_W;

   typedef enum logic [2:0] {
      PH_NONE,
      PH_MUL_N,
      PH_MUL_S,
      PH_SQRT,
      PH_DIV_SD,
      PH_DIV_MEAN
   } phase_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_DRAIN,
      ST_MUL_N,
      ST_MUL_S,
      ST_SQRT,
      ST_DIV_SD,
      ST_DIV_MEAN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      phase_type phase;
      logic      start;
      logic      load_out;
      logic      clear;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic out_blocked;
   } status_type;

endpackage

[src/msd_ctrl.sv]
// msd_ctrl: sequencer for the accumulate phase and the bit-serial
// finish phases (multiply, square root, divide). Uses msd_pkg.
module msd_ctrl
   import msd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   input  status_type sts,
   output logic       req_stall,
   output cmd_type    cmd
);

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [STEP_W-1:0]   step_last;
   logic                phase_done;

   // iteration count of the current phase
   always_comb begin
      case (state_ff)
         ST_MUL_N:    step_last = STEP_W'(MUL_N_STEPS);
         ST_MUL_S:    step_last = STEP_W'(MUL_S_STEPS);
         ST_SQRT:     step_last = STEP_W'(SQRT_STEPS);
         ST_DIV_SD:   step_last = STEP_W'(DIV_STEPS);
         ST_DIV_MEAN: step_last = STEP_W'(DIV_STEPS);
         default:     step_last = '0;
      endcase
   end

   assign phase_done = (step_ff == step_last);

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = '0;
      case (state_ff)
         ST_ACCUM: begin
            if (req_valid && req_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) state_in = ST_MUL_N;
         end
         ST_MUL_N, ST_MUL_S, ST_SQRT, ST_DIV_SD, ST_DIV_MEAN: begin
            if (phase_done) begin
               case (state_ff)
                  ST_MUL_N:  state_in = ST_MUL_S;
                  ST_MUL_S:  state_in = ST_SQRT;
                  ST_SQRT:   state_in = ST_DIV_SD;
                  ST_DIV_SD: state_in = ST_DIV_MEAN;
                  default:   state_in = ST_RESULT;
               endcase
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_RESULT: begin
            if (!sts.out_blocked) state_in = ST_ACCUM;
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   // commands to the datapath
   always_comb begin
      req_stall    = (state_ff != ST_ACCUM);
      cmd.phase    = PH_NONE;
      cmd.start    = (step_ff == '0);
      cmd.load_out = 1'b0;
      cmd.clear    = 1'b0;
      case (state_ff)
         ST_MUL_N:    cmd.phase = PH_MUL_N;
         ST_MUL_S:    cmd.phase = PH_MUL_S;
         ST_SQRT:     cmd.phase = PH_SQRT;
         ST_DIV_SD:   cmd.phase = PH_DIV_SD;
         ST_DIV_MEAN: cmd.phase = PH_DIV_MEAN;
         ST_RESULT: begin
            cmd.load_out = !sts.out_blocked;
            cmd.clear    = !sts.out_blocked;
         end
         default: cmd.phase = PH_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

[src/msd_dpath.sv]
// msd_dpath: sample accumulators, shared bit-serial multiply, square root
// and divide registers, and the result register. Uses msd_pkg.
module msd_dpath
   import msd_pkg::*;
#(
   parameter int MAX_SAMPLES = MSD_MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = MSD_SAMPLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_accept,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  cmd_type                    cmd,
   output status_type                 sts,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic signed [MEAN_W-1:0]   rsp_mean,
   output logic [SD_W-1:0]            rsp_std_dev,
   output logic [CNT_W-1:0]           rsp_sample_count,
   output logic                       rsp_overflow
);

   localparam int EXT_SHIFT = SAMPLE_W - SAMPLE_BITS;

   // accumulate pipeline
   logic signed [SAMPLE_W-1:0] smp_shl, smp_ext;
   logic                       a_vld_ff, b_vld_ff;
   logic signed [SAMPLE_W-1:0] a_smp_ff, b_smp_ff;
   logic signed [PROD_W-1:0]   prod;
   logic [PROD_W-1:0]          b_sq_ff;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       ovf_ff, ovf_in;
   logic                       sat;

   // finish registers
   logic [VAR_W-1:0]           work_ff, work_in;
   logic [VAR_W-1:0]           mcand_ff, mcand_in;
   logic [SUM_W-1:0]           mplier_ff, mplier_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [ROOT_W-1:0]          root_ff, root_in;
   logic [SUM_W-1:0]           dvd_ff, dvd_in;
   logic [CNT_W-1:0]           drem_ff, drem_in;
   logic [SD_W-1:0]            sd_ff, sd_in;
   logic [SUM_W-1:0]           abs_sum;
   logic [REM_W+1:0]           rem_t, trial, rem_diff;
   logic                       sq_ge;
   logic [CNT_W:0]             drem_t, n_ext, drem_diff;
   logic                       div_ge;

   // result register
   logic                       rsp_valid_ff;
   logic signed [MEAN_W-1:0]   mean_ff;
   logic [MEAN_W-1:0]          mean_q, mean_in;
   logic [SD_W-1:0]            out_sd_ff;
   logic [CNT_W-1:0]           out_cnt_ff;
   logic                       out_ovf_ff;

   // sign extension from the configured sample width
   assign smp_shl = req_sample <<< EXT_SHIFT;
   assign smp_ext = smp_shl >>> EXT_SHIFT;
   assign prod    = a_smp_ff * a_smp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= req_accept;
         b_vld_ff <= a_vld_ff;
      end
      a_smp_ff <= smp_ext;
      b_smp_ff <= a_smp_ff;
      b_sq_ff  <= unsigned'(prod);
   end

   // running sums, count saturates at the sample limit
   assign sat = (cnt_ff >= CNT_W'(MAX_SAMPLES));

   always_comb begin
      sum_in = sum_ff;
      sq_in  = sq_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (cmd.clear) begin
         sum_in = '0;
         sq_in  = '0;
         cnt_in = '0;
         ovf_in = 1'b0;
      end else if (b_vld_ff) begin
         if (sat) begin
            ovf_in = 1'b1;
         end else begin
            sum_in = sum_ff + {{(SUM_W-SAMPLE_W){b_smp_ff[SAMPLE_W-1]}}, b_smp_ff};
            sq_in  = sq_ff + {{(SQ_W-PROD_W){1'b0}}, b_sq_ff};
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         sq_ff  <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         sq_ff  <= sq_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

   assign abs_sum = sum_ff[SUM_W-1] ? unsigned'(-sum_ff) : unsigned'(sum_ff);

   // square root step: two bits of the radicand per cycle
   assign rem_t    = {rem_ff, work_ff[VAR_W-1 -: 2]};
   assign trial    = {{(REM_W-ROOT_W){1'b0}}, root_ff, 2'b01};
   assign rem_diff = rem_t - trial;
   assign sq_ge    = (rem_t >= trial);

   // restoring divide step by the sample count
   assign drem_t    = {drem_ff, dvd_ff[SUM_W-1]};
   assign n_ext     = {1'b0, cnt_ff};
   assign drem_diff = drem_t - n_ext;
   assign div_ge    = (drem_t >= n_ext);

   // finish phases: V = n*sumsq - sum^2, root = isqrt(V),
   // std_dev = root / n, mean = |sum| / n
   always_comb begin
      work_in   = work_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      dvd_in    = dvd_ff;
      drem_in   = drem_ff;
      sd_in     = sd_ff;
      case (cmd.phase)
         PH_MUL_N: begin
            if (cmd.start) begin
               work_in   = '0;
               mcand_in  = {{(VAR_W-SQ_W){1'b0}}, sq_ff};
               mplier_in = {{(SUM_W-CNT_W){1'b0}}, cnt_ff};
            end else begin
               if (mplier_ff[0]) work_in = work_ff + mcand_ff;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end
         PH_MUL_S: begin
            if (cmd.start) begin
               mcand_in  = {{(VAR_W-SUM_W){1'b0}}, abs_sum};
               mplier_in = abs_sum;
            end else begin
               if (mplier_ff[0]) work_in = work_ff - mcand_ff;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end
         PH_SQRT: begin
            if (cmd.start) begin
               rem_in  = '0;
               root_in = '0;
            end else begin
               rem_in  = sq_ge ? rem_diff[REM_W-1:0] : rem_t[REM_W-1:0];
               root_in = {root_ff[ROOT_W-2:0], sq_ge};
               work_in = work_ff << 2;
            end
         end
         PH_DIV_SD, PH_DIV_MEAN: begin
            if (cmd.start) begin
               if (cmd.phase == PH_DIV_MEAN) begin
                  sd_in  = dvd_ff[SD_W-1:0];
                  dvd_in = abs_sum;
               end else begin
                  dvd_in = root_ff;
               end
               drem_in = '0;
            end else begin
               dvd_in  = {dvd_ff[SUM_W-2:0], div_ge};
               drem_in = div_ge ? drem_diff[CNT_W-1:0] : drem_t[CNT_W-1:0];
            end
         end
         default: work_in = work_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      dvd_ff    <= dvd_in;
      drem_ff   <= drem_in;
      sd_ff     <= sd_in;
   end

   // signed mean from the quotient magnitude
   assign mean_q  = dvd_ff[MEAN_W-1:0];
   assign mean_in = sum_ff[SUM_W-1] ? (~mean_q + 1'b1) : mean_q;

   // result register, holds while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         mean_ff    <= signed'(mean_in);
         out_sd_ff  <= sd_ff;
         out_cnt_ff <= cnt_ff;
         out_ovf_ff <= ovf_ff;
      end
   end

   assign sts.pipe_busy   = a_vld_ff | b_vld_ff;
   assign sts.out_blocked = rsp_valid_ff & rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean         = mean_ff;
   assign rsp_std_dev      = out_sd_ff;
   assign rsp_sample_count = out_cnt_ff;
   assign rsp_overflow     = out_ovf_ff;

endmodule

[src/mean_and_std_deviation.sv]
// mean_and_std_deviation: top level, joins the sequencer and the datapath.
// Depends on msd_pkg, msd_ctrl and msd_dpath.
//
// Usage:
//   The request channel (req_valid, req_stall, req_sample, req_last) takes
//   one signed Q16.8 sample per request; req_last marks the final sample
//   of a vector. Samples are accepted one per cycle while a vector is
//   being accumulated.
//   After the last request is taken, req_stall stays high through a drain of
//   the square/accumulate pipeline, then the bit-serial phases (n*sumsq,
//   minus sum^2, integer square root, root / n, |sum| / n) on shift-and-add
//   registers, then the load of the result.
//   The response channel (rsp_valid, rsp_stall, rsp_*) carries the mean,
//   the population standard deviation, the sample count and an overflow
//   flag. The result sits in an output register: a stalled response holds
//   its value, and the next vector's samples are accepted meanwhile; the
//   block only waits at the end of that next vector if the old result
//   has still not been taken.
//   Synchronous reset clears the sums, the count and any pending response.
module mean_and_std_deviation
   import msd_pkg::*;
#(
   parameter int MAX_SAMPLES = MSD_MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = MSD_SAMPLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [MEAN_W-1:0]   rsp_mean,
   output logic [SD_W-1:0]            rsp_std_dev,
   output logic [CNT_W-1:0]           rsp_sample_count,
   output logic                       rsp_overflow
);

   cmd_type    cmd;
   status_type sts;
   logic       req_accept;

   assign req_accept = req_valid & ~req_stall;

   // sequencer
   msd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // arithmetic
   msd_dpath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_accept       (req_accept),
      .req_sample       (req_sample),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_mean         (rsp_mean),
      .rsp_std_dev      (rsp_std_dev),
      .rsp_sample_count (rsp_sample_count),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

[src/msd_checker.sv]
// msd_checker: port-level assertions for mean_and_std_deviation, and the
// bind that attaches them. Uses msd_pkg.
module msd_checker
   import msd_pkg::*;
#(
   parameter int MAX_SAMPLES = MSD_MAX_SAMPLES_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       req_last,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [MEAN_W-1:0]   rsp_mean,
   input logic [SD_W-1:0]            rsp_std_dev,
   input logic [CNT_W-1:0]           rsp_sample_count,
   input logic                       rsp_overflow
);

   // a stalled response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mean)
         && $stable(rsp_std_dev) && $stable(rsp_sample_count)
         && $stable(rsp_overflow))
      else $error("response changed while stalled");

   // the last request of a vector closes the request side for the finish
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> req_stall)
      else $error("request taken right after a last request");

   // a response counts at least one and at most the limit of samples
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_count != '0)
         && (rsp_sample_count <= CNT_W'(MAX_SAMPLES)))
      else $error("response sample count out of range");

   // overflow only with a saturated count
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_sample_count == CNT_W'(MAX_SAMPLES))
      else $error("overflow without a saturated count");

endmodule

bind mean_and_std_deviation msd_checker #(.MAX_SAMPLES(MAX_SAMPLES)) u_msd_checker (.*);
